// ===== sv/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared definitions for the process table scheduler
// Slot count, life state, request and status codes, and the table row type.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int LINK_W    = $clog2(NUM_SLOTS + 1);

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);

    localparam logic [2:0] LS_UNUSED   = 3'd0;
    localparam logic [2:0] LS_EMBRYO   = 3'd1;
    localparam logic [2:0] LS_SLEEPING = 3'd2;
    localparam logic [2:0] LS_RUNNABLE = 3'd3;
    localparam logic [2:0] LS_RUNNING  = 3'd4;
    localparam logic [2:0] LS_ZOMBIE   = 3'd5;

    localparam logic [3:0] RQ_ALLOC  = 4'd0;
    localparam logic [3:0] RQ_START  = 4'd1;
    localparam logic [3:0] RQ_SCHED  = 4'd2;
    localparam logic [3:0] RQ_YIELD  = 4'd3;
    localparam logic [3:0] RQ_SLEEP  = 4'd4;
    localparam logic [3:0] RQ_WAKEUP = 4'd5;
    localparam logic [3:0] RQ_KILL   = 4'd6;
    localparam logic [3:0] RQ_EXIT   = 4'd7;
    localparam logic [3:0] RQ_WAIT   = 4'd8;
    localparam logic [3:0] RQ_FREE   = 4'd9;

    localparam logic [1:0] RS_OK      = 2'd0;
    localparam logic [1:0] RS_FAIL    = 2'd1;
    localparam logic [1:0] RS_SLEEP   = 2'd2;
    localparam logic [1:0] RS_ILLEGAL = 2'd3;

    localparam logic CFG_INIT_SLOT = 1'b0;

    typedef struct packed {
        logic [2:0]        life;
        logic [30:0]       pid;
        logic [LINK_W-1:0] parent;
        logic [32:0]       chan;
        logic              killed;
    } t_row;

    localparam t_row ROW_RESET = '{life: LS_UNUSED, pid: 31'd0, parent: LINK_NONE,
                                   chan: 33'd0, killed: 1'b0};

    typedef struct packed {
        logic load;
        logic rd_slot;
        logic chk;
        logic rd_scan;
        logic pr_scan;
        logic rd_fix;
        logic pr_fix;
        logic fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic go_scan;
        logic hit;
        logic last;
        logic need_fix;
        logic need_fin;
        logic out_free;
    } t_sts;

    // Private wait channel of a slot: the marker bit over the slot number.
    function automatic logic [32:0] wait_chan(input logic [LINK_W-1:0] link);
        return {1'b1, 32'(link)};
    endfunction

endpackage

// ===== sv/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pts_ctrl: request sequencer
// Steps a request through slot read, check, table scan, fix-up and finish.
// ----------------------------------------------------------------------------
module pts_ctrl import pts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SC_RD = 4'd3;
    localparam logic [3:0] S_SC_PR = 4'd4;
    localparam logic [3:0] S_FX_RD = 4'd5;
    localparam logic [3:0] S_FX_PR = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_slot = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.go_scan ? S_SC_RD : S_DONE;
            end
            S_SC_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SC_PR;
            end
            S_SC_PR: begin
                o_cmd.pr_scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end else if (i_sts.last) begin
                    if (i_sts.need_fix) begin
                        n_state = S_FX_RD;
                    end else if (i_sts.need_fin) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_FX_RD: begin
                o_cmd.rd_fix = 1'b1;
                n_state      = S_FX_PR;
            end
            S_FX_PR: begin
                o_cmd.pr_fix = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pts_dpath.sv =====
// ----------------------------------------------------------------------------
// pts_dpath: process table and request datapath
// Holds the slot table memory, per-slot valid bits, the scan counter, the
// pid and round robin registers, and the result and output registers.
// ----------------------------------------------------------------------------
module pts_dpath import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [5:0]  i_init_slot,
    input  logic [3:0]  i_req_type,
    input  logic [5:0]  i_slot,
    input  logic [31:0] i_chan,
    input  logic [30:0] i_target_pid,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_result_slot,
    output logic [30:0] o_result_pid
);

    t_row              r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    t_row              r_rd_data;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_addr;

    logic [3:0]        r_req, n_req;
    logic [5:0]        r_slot, n_slot;
    logic [31:0]       r_chan, n_chan;
    logic [30:0]       r_tpid, n_tpid;
    logic              r_in_range, n_in_range;
    t_row              r_srow, n_srow;
    logic [LINK_W-1:0] r_alloc_par, n_alloc_par;
    logic [IDX_W-1:0]  r_k, n_k;
    logic              r_flag, n_flag;
    logic              r_kids, n_kids;
    logic [30:0]       r_next_pid, n_next_pid;
    logic [IDX_W-1:0]  r_rr, n_rr;
    logic [1:0]        r_res_st, n_res_st;
    logic [5:0]        r_res_slot, n_res_slot;
    logic [30:0]       r_res_pid, n_res_pid;
    logic              r_o_valid, n_o_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic [5:0]        r_o_slot, n_o_slot;
    logic [30:0]       r_o_pid, n_o_pid;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              w_en;
    logic [IDX_W-1:0]  w_addr;
    t_row              w_row;
    t_row              row;
    logic [IDX_W-1:0]  s_idx;
    logic [LINK_W-1:0] s_link;
    logic [LINK_W-1:0] adopt;
    logic [IDX_W:0]    rr_sum;
    logic [IDX_W:0]    rr_wrap;
    logic [IDX_W-1:0]  scan_addr;
    logic [IDX_W:0]    rr_inc;
    logic              last;

    assign row     = r_rd_vld ? r_rd_data : ROW_RESET;
    assign s_idx   = IDX_W'(r_slot);
    assign s_link  = LINK_W'(r_slot);
    assign adopt   = (32'(i_init_slot) < 32'(NUM_SLOTS)) ? LINK_W'(i_init_slot) : LINK_NONE;
    assign rr_sum  = {1'b0, r_rr} + {1'b0, r_k};
    assign rr_wrap = (rr_sum >= (IDX_W+1)'(NUM_SLOTS)) ? rr_sum - (IDX_W+1)'(NUM_SLOTS) : rr_sum;
    assign scan_addr = (r_req == RQ_SCHED) ? rr_wrap[IDX_W-1:0] : r_k;
    assign rr_inc  = {1'b0, r_rd_addr} + (IDX_W+1)'(1);
    assign last    = (r_k == IDX_W'(NUM_SLOTS - 1));

    always_comb begin
        n_req       = r_req;
        n_slot      = r_slot;
        n_chan      = r_chan;
        n_tpid      = r_tpid;
        n_in_range  = r_in_range;
        n_srow      = r_srow;
        n_alloc_par = r_alloc_par;
        n_k         = r_k;
        n_flag      = r_flag;
        n_kids      = r_kids;
        n_next_pid  = r_next_pid;
        n_rr        = r_rr;
        n_res_st    = r_res_st;
        n_res_slot  = r_res_slot;
        n_res_pid   = r_res_pid;
        n_o_valid   = r_o_valid;
        n_o_status  = r_o_status;
        n_o_slot    = r_o_slot;
        n_o_pid     = r_o_pid;
        rd_en       = 1'b0;
        rd_addr     = s_idx;
        w_en        = 1'b0;
        w_addr      = r_rd_addr;
        w_row       = row;
        o_sts       = '0;
        o_sts.last     = last;
        o_sts.out_free = !r_o_valid || i_out_ready;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_req      = i_req_type;
            n_slot     = i_slot;
            n_chan     = i_chan;
            n_tpid     = i_target_pid;
            n_in_range = (32'(i_slot) < 32'(NUM_SLOTS));
            n_k        = '0;
            n_flag     = 1'b0;
            n_kids     = 1'b0;
        end

        if (i_cmd.rd_slot) begin
            rd_en   = 1'b1;
            rd_addr = s_idx;
        end

        if (i_cmd.chk) begin
            n_srow      = row;
            n_alloc_par = (r_in_range && row.life != LS_UNUSED) ? s_link : LINK_NONE;
            n_res_st    = RS_ILLEGAL;
            n_res_slot  = '0;
            n_res_pid   = '0;
            w_addr      = s_idx;
            case (r_req)
                RQ_ALLOC, RQ_SCHED, RQ_KILL: begin
                    n_res_st      = RS_FAIL;
                    o_sts.go_scan = 1'b1;
                end
                RQ_WAKEUP: begin
                    n_res_st      = RS_OK;
                    o_sts.go_scan = 1'b1;
                end
                RQ_START: begin
                    if (r_in_range && row.life == LS_EMBRYO) begin
                        w_en       = 1'b1;
                        w_row.life = LS_RUNNABLE;
                        n_res_st   = RS_OK;
                    end
                end
                RQ_YIELD: begin
                    if (r_in_range && row.life == LS_RUNNING) begin
                        w_en       = 1'b1;
                        w_row.life = LS_RUNNABLE;
                        n_res_st   = RS_OK;
                    end
                end
                RQ_SLEEP: begin
                    if (r_in_range && row.life == LS_RUNNING) begin
                        w_en       = 1'b1;
                        w_row.life = LS_SLEEPING;
                        w_row.chan = {1'b0, r_chan};
                        n_res_st   = RS_SLEEP;
                    end
                end
                RQ_EXIT: begin
                    if (r_in_range && r_slot != i_init_slot && row.life == LS_RUNNING) begin
                        n_res_st      = RS_OK;
                        o_sts.go_scan = 1'b1;
                    end
                end
                RQ_WAIT: begin
                    if (r_in_range && row.life == LS_RUNNING) begin
                        o_sts.go_scan = 1'b1;
                    end
                end
                RQ_FREE: begin
                    if (r_in_range && row.life == LS_EMBRYO) begin
                        w_en     = 1'b1;
                        w_row    = ROW_RESET;
                        n_res_st = RS_OK;
                    end
                end
                default: begin
                    n_res_st = RS_ILLEGAL;
                end
            endcase
        end

        if (i_cmd.rd_scan) begin
            rd_en   = 1'b1;
            rd_addr = scan_addr;
        end

        if (i_cmd.pr_scan) begin
            n_k = r_k + IDX_W'(1);
            case (r_req)
                RQ_ALLOC: begin
                    if (row.life == LS_UNUSED) begin
                        o_sts.hit = 1'b1;
                        w_en      = 1'b1;
                        w_row     = '{life: LS_EMBRYO, pid: r_next_pid, parent: r_alloc_par,
                                      chan: 33'd0, killed: 1'b0};
                        // An unused requester that gets the new slot is in use by then,
                        // so it becomes its own parent.
                        if (r_in_range && r_rd_addr == s_idx) begin
                            w_row.parent = s_link;
                        end
                        n_next_pid = (r_next_pid == 31'h7FFF_FFFF) ? 31'd1 : r_next_pid + 31'd1;
                        n_res_st   = RS_OK;
                        n_res_slot = 6'(r_rd_addr);
                        n_res_pid  = r_next_pid;
                    end
                end
                RQ_SCHED: begin
                    if (row.life == LS_RUNNABLE) begin
                        o_sts.hit  = 1'b1;
                        w_en       = 1'b1;
                        w_row.life = LS_RUNNING;
                        n_rr       = (rr_inc == (IDX_W+1)'(NUM_SLOTS)) ? '0 : rr_inc[IDX_W-1:0];
                        n_res_st   = RS_OK;
                        n_res_slot = 6'(r_rd_addr);
                    end
                end
                RQ_WAKEUP: begin
                    if (row.life == LS_SLEEPING && row.chan == {1'b0, r_chan}) begin
                        w_en       = 1'b1;
                        w_row.life = LS_RUNNABLE;
                        w_row.chan = '0;
                    end
                end
                RQ_KILL: begin
                    if (row.life != LS_UNUSED && row.pid == r_tpid) begin
                        o_sts.hit    = 1'b1;
                        w_en         = 1'b1;
                        w_row.killed = 1'b1;
                        if (row.life == LS_SLEEPING) begin
                            w_row.life = LS_RUNNABLE;
                            w_row.chan = '0;
                        end
                        n_res_st = RS_OK;
                    end
                end
                RQ_EXIT: begin
                    w_en = 1'b1;
                    // The parent's wake and the hand-over of children touch
                    // different fields, so one pass serves both.
                    if (r_srow.parent != LINK_NONE && row.life == LS_SLEEPING &&
                        row.chan == wait_chan(r_srow.parent)) begin
                        w_row.life = LS_RUNNABLE;
                        w_row.chan = '0;
                    end
                    if (row.parent == s_link) begin
                        w_row.parent = adopt;
                        if (row.life == LS_ZOMBIE && adopt != LINK_NONE) begin
                            n_flag = 1'b1;
                        end
                    end
                end
                RQ_WAIT: begin
                    if (row.parent == s_link) begin
                        n_kids = 1'b1;
                        if (row.life == LS_ZOMBIE) begin
                            o_sts.hit  = 1'b1;
                            w_en       = 1'b1;
                            w_row      = ROW_RESET;
                            n_res_st   = RS_OK;
                            n_res_slot = 6'(r_rd_addr);
                            n_res_pid  = row.pid;
                        end
                    end
                end
                default: begin
                    w_en = 1'b0;
                end
            endcase
            o_sts.need_fix = (r_req == RQ_EXIT) && n_flag;
            o_sts.need_fin = (r_req == RQ_EXIT) || (r_req == RQ_WAIT);
        end

        // Only init itself can sleep on init's wait channel.
        if (i_cmd.rd_fix) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(adopt);
        end

        if (i_cmd.pr_fix) begin
            if (row.life == LS_SLEEPING && row.chan == wait_chan(adopt)) begin
                w_en       = 1'b1;
                w_row.life = LS_RUNNABLE;
                w_row.chan = '0;
            end
        end

        if (i_cmd.fin) begin
            w_addr = s_idx;
            w_row  = r_srow;
            if (r_req == RQ_EXIT) begin
                w_en       = 1'b1;
                w_row.life = LS_ZOMBIE;
                // A slot that is its own parent was handed to init by the scan.
                if (r_srow.parent == s_link) begin
                    w_row.parent = adopt;
                end
                n_res_st   = RS_OK;
            end else if (!r_kids || r_srow.killed) begin
                n_res_st = RS_FAIL;
            end else begin
                w_en       = 1'b1;
                w_row.life = LS_SLEEPING;
                w_row.chan = wait_chan(s_link);
                n_res_st   = RS_SLEEP;
            end
        end

        if (i_cmd.out_load) begin
            n_o_valid  = 1'b1;
            n_o_status = r_res_st;
            n_o_slot   = r_res_slot;
            n_o_pid    = r_res_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_row;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_next_pid <= 31'd1;
            r_rr       <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld[w_addr] <= 1'b1;
            end
            r_next_pid <= n_next_pid;
            r_rr       <= n_rr;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_slot      <= n_slot;
        r_chan      <= n_chan;
        r_tpid      <= n_tpid;
        r_in_range  <= n_in_range;
        r_srow      <= n_srow;
        r_alloc_par <= n_alloc_par;
        r_k         <= n_k;
        r_flag      <= n_flag;
        r_kids      <= n_kids;
        r_res_st    <= n_res_st;
        r_res_slot  <= n_res_slot;
        r_res_pid   <= n_res_pid;
        r_o_status  <= n_o_status;
        r_o_slot    <= n_o_slot;
        r_o_pid     <= n_o_pid;
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_result_slot = r_o_slot;
    assign o_result_pid  = r_o_pid;

endmodule

// ===== sv/process_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// process_table_scheduler: round robin process table scheduler
// Serves one process table request at a time and returns one result.
// ----------------------------------------------------------------------------
// One request is in work at a time. Start, yield, sleep, free and any
// illegal request present their result after the slot read and the check,
// and the next request can be taken once the result is loaded into the output register. Alloc, schedule, wakeup, kill,
// exit and wait walk the table with a read step and a process step per slot
// through the single read port of the table memory, over up to all 64 slots;
// exit, and a wait that finds no zombie child, then update the caller's slot
// in a finish step, and an exit that hands a zombie to init adds a fix-up read
// and process step to wake init. The result stays in an output register while the next request
// is taken. The table needs no clearing pass.
module process_table_scheduler import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_req_type,
    input  logic [5:0]  i_slot,
    input  logic [31:0] i_chan,
    input  logic [30:0] i_target_pid,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_result_slot,
    output logic [30:0] o_result_pid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0] r_init_slot;
    t_cmd       cmd;
    t_sts       sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_slot <= '0;
        end else if (psel && penable && pwrite && paddr[2] == CFG_INIT_SLOT) begin
            r_init_slot <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2] == CFG_INIT_SLOT) ? {26'd0, r_init_slot} : 32'd0;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pts_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_init_slot   (r_init_slot),
        .i_req_type    (i_req_type),
        .i_slot        (i_slot),
        .i_chan        (i_chan),
        .i_target_pid  (i_target_pid),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_result_pid  (o_result_pid)
    );

endmodule

// ===== sv/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker: port level checks for the process table scheduler
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module pts_checker import pts_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [5:0]  o_result_slot,
    input logic [30:0] o_result_pid
);

    // A pending result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_result_slot) && $stable(o_result_pid))
        else $error("result changed before transfer");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    // Only a successful request reports a slot or a pid.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != RS_OK |-> o_result_slot == 6'd0 && o_result_pid == 31'd0)
        else $error("failed request reports a slot or pid");

    // A new result never appears in the cycle right after a transfer.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind process_table_scheduler pts_checker u_pts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_result_slot (o_result_slot),
    .o_result_pid  (o_result_pid)
);

// ===== tb/sv/process_table_scheduler_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// process_table_scheduler_checker: result predictor and comparator
// Watches the request and result channels and the register port, keeps its
// own copy of the process table, and checks every result against it.
// ----------------------------------------------------------------------------
module process_table_scheduler_checker import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [3:0]  i_req_type,
    input  logic [5:0]  i_slot,
    input  logic [31:0] i_chan,
    input  logic [30:0] i_target_pid,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [5:0]  i_result_slot,
    input  logic [30:0] i_result_pid,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  rslot;
        logic [30:0] rpid;
    } t_answer;

    logic [2:0]        tbl_life   [NUM_SLOTS];
    logic [30:0]       tbl_pid    [NUM_SLOTS];
    logic [LINK_W-1:0] tbl_parent [NUM_SLOTS];
    logic [32:0]       tbl_chan   [NUM_SLOTS];
    logic              tbl_killed [NUM_SLOTS];
    logic [30:0]       pid_next;
    logic [IDX_W-1:0]  rr_next;
    logic [5:0]        init_reg;
    t_answer           answer_q[$];

    function automatic void wake(input logic [32:0] ch);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (tbl_life[i] == LS_SLEEPING && tbl_chan[i] == ch) begin
                tbl_life[i] = LS_RUNNABLE;
                tbl_chan[i] = '0;
            end
    endfunction

    function automatic void wipe(input int s);
        tbl_life[s] = LS_UNUSED;
        tbl_pid[s] = '0;
        tbl_parent[s] = LINK_NONE;
        tbl_chan[s] = '0;
        tbl_killed[s] = 1'b0;
    endfunction

    function automatic t_answer serve(input logic [3:0] rq, input logic [5:0] s,
                                      input logic [31:0] ch, input logic [30:0] tp);
        t_answer a;
        logic [LINK_W-1:0] adopt;
        a = '{RS_OK, 6'd0, 31'd0};
        case (rq)
            RQ_ALLOC: begin
                a.status = RS_FAIL;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_life[i] == LS_UNUSED) begin
                        // The new slot is in use before its parent is chosen.
                        tbl_life[i] = LS_EMBRYO;
                        tbl_parent[i] = (int'(s) < NUM_SLOTS && tbl_life[s] != LS_UNUSED)
                                        ? LINK_W'(s) : LINK_NONE;
                        tbl_pid[i] = pid_next;
                        tbl_chan[i] = '0;
                        tbl_killed[i] = 1'b0;
                        a = '{RS_OK, 6'(i), pid_next};
                        pid_next = pid_next + 31'd1;
                        if (pid_next == 0) pid_next = 31'd1;
                        return a;
                    end
                return '{RS_FAIL, 6'd0, 31'd0};
            end
            RQ_SCHED: begin
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    int i;
                    i = (int'(rr_next) + k) % NUM_SLOTS;
                    if (tbl_life[i] == LS_RUNNABLE) begin
                        tbl_life[i] = LS_RUNNING;
                        rr_next = IDX_W'((i + 1) % NUM_SLOTS);
                        return '{RS_OK, 6'(i), 31'd0};
                    end
                end
                return '{RS_FAIL, 6'd0, 31'd0};
            end
            RQ_WAKEUP: begin
                wake({1'b0, ch});
                return a;
            end
            RQ_KILL: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_life[i] != LS_UNUSED && tbl_pid[i] == tp) begin
                        tbl_killed[i] = 1'b1;
                        if (tbl_life[i] == LS_SLEEPING) begin
                            tbl_life[i] = LS_RUNNABLE;
                            tbl_chan[i] = '0;
                        end
                        return a;
                    end
                return '{RS_FAIL, 6'd0, 31'd0};
            end
            default: ;
        endcase
        if (rq > RQ_FREE || int'(s) >= NUM_SLOTS)
            return '{RS_ILLEGAL, 6'd0, 31'd0};
        case (rq)
            RQ_START, RQ_FREE: begin
                if (tbl_life[s] != LS_EMBRYO) return '{RS_ILLEGAL, 6'd0, 31'd0};
                if (rq == RQ_START) tbl_life[s] = LS_RUNNABLE;
                else wipe(s);
            end
            RQ_YIELD: begin
                if (tbl_life[s] != LS_RUNNING) return '{RS_ILLEGAL, 6'd0, 31'd0};
                tbl_life[s] = LS_RUNNABLE;
            end
            RQ_SLEEP: begin
                if (tbl_life[s] != LS_RUNNING) return '{RS_ILLEGAL, 6'd0, 31'd0};
                tbl_life[s] = LS_SLEEPING;
                tbl_chan[s] = {1'b0, ch};
                a.status = RS_SLEEP;
            end
            RQ_EXIT: begin
                adopt = (int'(init_reg) < NUM_SLOTS) ? LINK_W'(init_reg) : LINK_NONE;
                if (s == init_reg || tbl_life[s] != LS_RUNNING)
                    return '{RS_ILLEGAL, 6'd0, 31'd0};
                if (int'(tbl_parent[s]) < NUM_SLOTS) wake(wait_chan(tbl_parent[s]));
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_parent[i] == LINK_W'(s)) begin
                        tbl_parent[i] = adopt;
                        if (tbl_life[i] == LS_ZOMBIE && adopt != LINK_NONE)
                            wake(wait_chan(adopt));
                    end
                tbl_life[s] = LS_ZOMBIE;
            end
            RQ_WAIT: begin
                bit kids;
                kids = 1'b0;
                if (tbl_life[s] != LS_RUNNING) return '{RS_ILLEGAL, 6'd0, 31'd0};
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_parent[i] == LINK_W'(s)) begin
                        kids = 1'b1;
                        if (tbl_life[i] == LS_ZOMBIE) begin
                            a = '{RS_OK, 6'(i), tbl_pid[i]};
                            wipe(i);
                            return a;
                        end
                    end
                end
                if (!kids || tbl_killed[s]) return '{RS_FAIL, 6'd0, 31'd0};
                tbl_life[s] = LS_SLEEPING;
                tbl_chan[s] = wait_chan(LINK_W'(s));
                a.status = RS_SLEEP;
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) wipe(i);
            pid_next = 31'd1;
            rr_next = '0;
            init_reg = '0;
            answer_q.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == CFG_INIT_SLOT)
                init_reg = i_pwdata[5:0];
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_result_slot, i_result_pid};
                o_results_seen <= o_results_seen + 1;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                                 $realtime, want.status, want.rslot, want.rpid,
                                 got.status, got.rslot, got.rpid);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                answer_q.push_back(serve(i_req_type, i_slot, i_chan, i_target_pid));
        end
        o_pending <= answer_q.size();
    end

endmodule

// ===== tb/sv/process_table_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// process_table_scheduler_tb: stimulus and verdict for the scheduler
// Drives directed and random process table requests with random gaps and
// output stalls, rewrites init_slot between phases, and reports the verdict.
// ----------------------------------------------------------------------------
module process_table_scheduler_tb;
    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic [3:0]  i_req_type;
    logic [5:0]  i_slot;
    logic [31:0] i_chan;
    logic [30:0] i_target_pid;
    logic        o_out_valid, i_out_ready;
    logic [1:0]  o_status;
    logic [5:0]  o_result_slot;
    logic [30:0] o_result_pid;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, results_seen;
    int          idle_cycles;
    int          requests_sent;
    bit          stall_enable;
    logic [30:0] pid_seen[$];

    process_table_scheduler dut (.*);

    process_table_scheduler_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_req_type, .i_slot,
        .i_chan, .i_target_pid, .i_out_valid(o_out_valid), .i_out_ready, .i_status(o_status),
        .i_result_slot(o_result_slot), .i_result_pid(o_result_pid), .i_psel(psel),
        .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr), .i_pwdata(pwdata),
        .i_pready(pready), .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // When stall_enable is set, the result side drops ready for a random hold-off after each transfer.
    initial begin
        int wait_n;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                wait_n = stall_enable ? $urandom_range(0, 11) : 0;
                if (wait_n != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (wait_n) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $realtime, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (o_out_valid && i_out_ready && o_status == RS_OK && o_result_pid != 0)
            pid_seen.push_back(o_result_pid);
    end

    task automatic send(input logic [3:0] rq, input logic [5:0] s,
                        input logic [31:0] ch, input logic [30:0] tp);
        int gap;
        gap = stall_enable ? $urandom_range(0, 11) : 0;
        repeat (gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= rq;
        i_slot <= s;
        i_chan <= ch;
        i_target_pid <= tp;
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
        requests_sent++;
    endtask

    // The pending count is a registered copy of the checker's queue size.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0 || o_out_valid) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_init(input logic [5:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {CFG_INIT_SLOT, 2'b00};
        pwdata <= {26'(~0) & 26'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly slot-directed lifecycle traffic on slots 0 to hot, some noise.
    task automatic random_request(input int hot);
        logic [3:0]  rq;
        logic [5:0]  s;
        logic [31:0] ch;
        logic [30:0] tp;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) rq = RQ_ALLOC;
        else if (pick < 32) rq = RQ_START;
        else if (pick < 50) rq = RQ_SCHED;
        else if (pick < 95) rq = 4'($urandom_range(3, 9));
        else rq = 4'($urandom_range(0, 15));
        s = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, hot)) : 6'($urandom);
        ch = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 3)) : $urandom;
        if (pid_seen.size() != 0 && $urandom_range(0, 3) != 0)
            tp = pid_seen[$urandom_range(0, pid_seen.size() - 1)];
        else
            tp = 31'($urandom);
        send(rq, s, ch, tp);
    endtask

    initial begin
        logic [5:0] init_choice[4];
        init_choice = '{6'd0, 6'd63, 6'd1, 6'd5};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = '0;
        i_slot = '0;
        i_chan = '0;
        i_target_pid = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_enable = 1'b0;
        requests_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_init(6'd0);

        // Directed: a parent, a child that exits, reaping, failures and junk.
        send(RQ_SCHED, 6'd0, 32'd0, 31'd0);
        send(RQ_ALLOC, 6'd63, 32'd0, 31'd0);
        send(RQ_ALLOC, 6'd0, 32'd0, 31'd0);
        send(RQ_ALLOC, 6'd0, 32'd0, 31'd0);
        send(RQ_FREE, 6'd2, 32'd0, 31'd0);
        send(RQ_FREE, 6'd2, 32'd0, 31'd0);
        send(RQ_START, 6'd0, 32'd0, 31'd0);
        send(RQ_START, 6'd1, 32'd0, 31'd0);
        send(RQ_SCHED, 6'd0, 32'd0, 31'd0);
        send(RQ_EXIT, 6'd0, 32'd0, 31'd0);
        send(RQ_SCHED, 6'd0, 32'd0, 31'd0);
        send(RQ_SLEEP, 6'd1, 32'hFFFF_FFFF, 31'd0);
        send(RQ_WAKEUP, 6'd0, 32'hFFFF_FFFF, 31'd0);
        send(RQ_SCHED, 6'd0, 32'd0, 31'd0);
        send(RQ_YIELD, 6'd1, 32'd0, 31'd0);
        send(RQ_SCHED, 6'd0, 32'd0, 31'd0);
        send(RQ_SCHED, 6'd0, 32'd0, 31'd0);
        send(RQ_WAIT, 6'd0, 32'd0, 31'd0);
        send(RQ_KILL, 6'd0, 32'd0, 31'h7FFF_FFFF);
        send(RQ_KILL, 6'd0, 32'd0, 31'd2);
        send(RQ_EXIT, 6'd1, 32'd0, 31'd0);
        send(RQ_WAIT, 6'd0, 32'd0, 31'd0);
        send(4'd15, 6'd0, 32'd0, 31'd0);
        send(4'd10, 6'd63, 32'd0, 31'd0);
        drain();

        stall_enable = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            write_init(init_choice[phase]);
            for (int n = 0; n < 250; n++) begin
                random_request(phase == 1 ? 63 : 7);
                // One hold-off until every result is back.
                if (phase == 2 && n == 100) begin
                    @(posedge i_clk);
                    while (pending != 0 || o_out_valid) @(posedge i_clk);
                end
                if (n == 125) stall_enable = 1'b0;
                if (n == 175) stall_enable = 1'b1;
            end
            drain();
        end

        $display("Covered %0d requests and %0d results over five init_slot settings.",
                 requests_sent, results_seen);
        $display("Random traffic mixed lifecycle requests with gaps and output stalls.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
